// ===== hdl/fmcl_pkg.sv =====
// Shared constants and types for the Fenwick prefix-max chain length engine.
package fmcl_pkg;

  localparam int TREE_SIZE = 4096;
  localparam int ADDR_W    = $clog2(TREE_SIZE);
  localparam int IDX_W     = $clog2(TREE_SIZE + 1);
  localparam int UPD_W     = $clog2(2 * TREE_SIZE + 1);
  localparam int LEN_W     = 13;
  localparam int RANK_W    = 13;

  localparam logic [LEN_W-1:0]  LEN_MAX          = {LEN_W{1'b1}};
  localparam logic [RANK_W-1:0] RANK_COUNT_RESET = RANK_W'(4096);

  localparam logic REQ_ELEMENT = 1'b0;
  localparam logic REQ_CLEAR   = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_QUERY,
    ST_CHAIN,
    ST_UPDATE,
    ST_DONE
  } state_t;

endpackage

// ===== hdl/fenwick_max_chain_length.sv =====
// Longest increasing chain engine: prefix-max Fenwick tree held in one synchronous RAM.
// Element: query walk, then update walk (skipped if the rank is zero or above rank_count
// or the tree size); q = set bits walked by the query, u = nodes visited by the update;
// q + u <= 13, one RAM access a cycle; no new item is taken until the result is registered.
// Clear: a sweep that writes zero to all 4096 tree RAM entries, then the result.
// Reset (rst_n, synchronous): the same sweep runs first; no input is taken during it.
module fenwick_max_chain_length (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [fmcl_pkg::RANK_W-1:0] cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_req_type,
  input  logic [fmcl_pkg::RANK_W-1:0] in_rank,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [fmcl_pkg::LEN_W-1:0]  out_chain_here,
  output logic [fmcl_pkg::LEN_W-1:0]  out_best_length
);

  localparam int ADDR_W = fmcl_pkg::ADDR_W;
  localparam int IDX_W  = fmcl_pkg::IDX_W;
  localparam int UPD_W  = fmcl_pkg::UPD_W;
  localparam int LEN_W  = fmcl_pkg::LEN_W;
  localparam int RANK_W = fmcl_pkg::RANK_W;

  // tree RAM, node i stored at address i-1
  logic [LEN_W-1:0] tree_mem [fmcl_pkg::TREE_SIZE];

  fmcl_pkg::state_t state_r, state_nxt;
  logic [RANK_W-1:0] rank_count_r;
  logic [IDX_W-1:0]  qidx_r, qidx_nxt;
  logic [UPD_W-1:0]  uidx_r, uidx_nxt;
  logic [LEN_W-1:0]  acc_r, acc_nxt;
  logic [LEN_W-1:0]  chain_r, chain_nxt;
  logic [LEN_W-1:0]  best_r, best_nxt;
  logic [RANK_W-1:0] rank_r, rank_nxt;
  logic              rd_pend_r, rd_pend_nxt;
  logic [ADDR_W-1:0] wb_addr_r, wb_addr_nxt;
  logic [ADDR_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic              report_r, report_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [LEN_W-1:0]  out_chain_r, out_chain_nxt;
  logic [LEN_W-1:0]  out_best_r, out_best_nxt;
  logic [LEN_W-1:0]  rdata_r;

  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [LEN_W-1:0]  wr_data;
  logic [UPD_W-1:0]  limit;
  logic              in_accept;

  assign in_stall        = (state_r != fmcl_pkg::ST_IDLE);
  assign in_accept       = in_valid && !in_stall;
  assign out_valid       = out_valid_r;
  assign out_chain_here  = out_chain_r;
  assign out_best_length = out_best_r;

  // update bound: rank_count capped at the tree size
  always_comb begin
    if (32'(rank_count_r) > 32'(fmcl_pkg::TREE_SIZE)) begin
      limit = UPD_W'(fmcl_pkg::TREE_SIZE);
    end else begin
      limit = UPD_W'(rank_count_r);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      tree_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= tree_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= fmcl_pkg::ST_CLEAR;
      rank_count_r <= fmcl_pkg::RANK_COUNT_RESET;
      best_r       <= '0;
      rd_pend_r    <= 1'b0;
      clr_cnt_r    <= '0;
      report_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      best_r    <= best_nxt;
      rd_pend_r <= rd_pend_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      report_r  <= report_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        rank_count_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    qidx_r      <= qidx_nxt;
    uidx_r      <= uidx_nxt;
    acc_r       <= acc_nxt;
    chain_r     <= chain_nxt;
    rank_r      <= rank_nxt;
    wb_addr_r   <= wb_addr_nxt;
    out_chain_r <= out_chain_nxt;
    out_best_r  <= out_best_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    qidx_nxt      = qidx_r;
    uidx_nxt      = uidx_r;
    acc_nxt       = acc_r;
    chain_nxt     = chain_r;
    best_nxt      = best_r;
    rank_nxt      = rank_r;
    rd_pend_nxt   = rd_pend_r;
    wb_addr_nxt   = wb_addr_r;
    clr_cnt_nxt   = clr_cnt_r;
    report_nxt    = report_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_chain_nxt = out_chain_r;
    out_best_nxt  = out_best_r;
    rd_en         = 1'b0;
    rd_addr       = '0;
    wr_en         = 1'b0;
    wr_addr       = '0;
    wr_data       = '0;

    case (state_r)
      fmcl_pkg::ST_CLEAR: begin
        wr_en       = 1'b1;
        wr_addr     = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + ADDR_W'(1);
        if (clr_cnt_r == ADDR_W'(fmcl_pkg::TREE_SIZE - 1)) begin
          clr_cnt_nxt = '0;
          state_nxt   = report_r ? fmcl_pkg::ST_DONE : fmcl_pkg::ST_IDLE;
        end
      end

      fmcl_pkg::ST_IDLE: begin
        if (in_accept) begin
          if (in_req_type == fmcl_pkg::REQ_CLEAR) begin
            best_nxt    = '0;
            chain_nxt   = '0;
            report_nxt  = 1'b1;
            clr_cnt_nxt = '0;
            state_nxt   = fmcl_pkg::ST_CLEAR;
          end else begin
            rank_nxt    = in_rank;
            acc_nxt     = '0;
            rd_pend_nxt = 1'b0;
            // query covers ranks below this one, capped at the tree size
            if (in_rank == '0) begin
              qidx_nxt = '0;
            end else if (32'(in_rank) - 32'd1 > 32'(fmcl_pkg::TREE_SIZE)) begin
              qidx_nxt = IDX_W'(fmcl_pkg::TREE_SIZE);
            end else begin
              qidx_nxt = IDX_W'(in_rank - RANK_W'(1));
            end
            state_nxt = fmcl_pkg::ST_QUERY;
          end
        end
      end

      fmcl_pkg::ST_QUERY: begin
        // fold in the node read last cycle
        if (rd_pend_r && (rdata_r > acc_r)) begin
          acc_nxt = rdata_r;
        end
        if (qidx_r != '0) begin
          rd_en       = 1'b1;
          rd_addr     = ADDR_W'(qidx_r - IDX_W'(1));
          qidx_nxt    = qidx_r - (qidx_r & (~qidx_r + IDX_W'(1)));
          rd_pend_nxt = 1'b1;
        end else begin
          rd_pend_nxt = 1'b0;
          state_nxt   = fmcl_pkg::ST_CHAIN;
        end
      end

      fmcl_pkg::ST_CHAIN: begin
        chain_nxt = (acc_r == fmcl_pkg::LEN_MAX) ? acc_r : acc_r + LEN_W'(1);
        if (chain_nxt > best_r) begin
          best_nxt = chain_nxt;
        end
        rd_pend_nxt = 1'b0;
        if ((rank_r == '0) || (32'(rank_r) > 32'(limit))) begin
          state_nxt = fmcl_pkg::ST_DONE;
        end else begin
          uidx_nxt  = UPD_W'(rank_r);
          state_nxt = fmcl_pkg::ST_UPDATE;
        end
      end

      fmcl_pkg::ST_UPDATE: begin
        // write back the node read last cycle if the new chain beats it
        if (rd_pend_r && (rdata_r < chain_r)) begin
          wr_en   = 1'b1;
          wr_addr = wb_addr_r;
          wr_data = chain_r;
        end
        if (uidx_r <= limit) begin
          rd_en       = 1'b1;
          rd_addr     = ADDR_W'(uidx_r - UPD_W'(1));
          wb_addr_nxt = ADDR_W'(uidx_r - UPD_W'(1));
          uidx_nxt    = uidx_r + (uidx_r & (~uidx_r + UPD_W'(1)));
          rd_pend_nxt = 1'b1;
        end else begin
          rd_pend_nxt = 1'b0;
          state_nxt   = fmcl_pkg::ST_DONE;
        end
      end

      fmcl_pkg::ST_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_chain_nxt = chain_r;
          out_best_nxt  = best_r;
          report_nxt    = 1'b0;
          state_nxt     = fmcl_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = fmcl_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
